### sv/gai_pkg.sv
// ----------------------------------------------------------------------------
// gai_pkg
// Shared constants, codes, command and status types for the gyro angle
// integrator.
// ----------------------------------------------------------------------------
package gai_pkg;

    localparam int unsigned SAMPLE_DEPTH = 1024;
    localparam int unsigned RATE_BITS    = 32;
    localparam int unsigned ADDR_W       = $clog2(SAMPLE_DEPTH);
    localparam int unsigned CNT_W        = $clog2(SAMPLE_DEPTH + 1);
    localparam int unsigned RATE_SH      = 32 - RATE_BITS;
    localparam int unsigned N_AXES       = 3;
    localparam int unsigned MUL_STEPS    = 64;
    localparam int unsigned STEP_W       = $clog2(MUL_STEPS);

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic signed [63:0] ANG_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ANG_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [4:0] {
        DP_NONE,
        DP_LOAD,
        DP_PUSH_FIRST,
        DP_MUL_PUSH,
        DP_MUL_STEP,
        DP_PUSH_FIN,
        DP_PUSH_WR,
        DP_CLEAR,
        DP_SRCH_INIT,
        DP_SRCH_RD,
        DP_SRCH_CMP,
        DP_FETCH_HI,
        DP_FETCH_LO,
        DP_DIRECT,
        DP_INTERP,
        DP_DIV_STEP,
        DP_INTERP_END,
        DP_DIFF,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] code;
        logic       side;
    } t_ctl;

    typedef struct packed {
        logic [1:0] opcode;
        logic       held_zero;
        logic       not_rising;
        logic       full;
        logic       query_bad;
        logic       srch_done;
        logic       lo_edge;
        logic       out_busy;
    } t_sts;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? ANG_MIN : ANG_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? ANG_MIN : ANG_MAX;
        end
        return s[63:0];
    endfunction

    // Keeps the low RATE_BITS bits and sign-extends from the top one of them.
    function automatic logic signed [31:0] rate_sext(input logic [31:0] v);
        logic signed [31:0] t;
        t = signed'(v << RATE_SH);
        return t >>> RATE_SH;
    endfunction

endpackage

### sv/gai_in_if.sv
// ----------------------------------------------------------------------------
// gai_in_if
// Request channel: opcode, sample stamp and rates, query interval.
// ----------------------------------------------------------------------------
interface gai_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [62:0]        sample_ns;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic [62:0]        start_ns;
    logic [62:0]        end_ns;

    modport source (output valid, opcode, sample_ns, rate_x, rate_y, rate_z,
                    start_ns, end_ns, input ready);
    modport sink   (input valid, opcode, sample_ns, rate_x, rate_y, rate_z,
                    start_ns, end_ns, output ready);
endinterface

### sv/gai_out_if.sv
// ----------------------------------------------------------------------------
// gai_out_if
// Result channel: status and the three angle changes.
// ----------------------------------------------------------------------------
interface gai_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [63:0] turn_x;
    logic signed [63:0] turn_y;
    logic signed [63:0] turn_z;

    modport source (output valid, status, turn_x, turn_y, turn_z, input ready);
    modport sink   (input valid, status, turn_x, turn_y, turn_z, output ready);
endinterface

### sv/gai_datapath.sv
// ----------------------------------------------------------------------------
// gai_datapath
// Sample stores, running angles, search registers and three arithmetic lanes
// with a shared shift-add multiplier and restoring divider per axis.
// ----------------------------------------------------------------------------
module gai_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gai_pkg::t_ctl        i_ctl,
    output gai_pkg::t_sts        o_sts,
    input  logic [1:0]           i_opcode,
    input  logic [62:0]          i_sample_ns,
    input  logic signed [31:0]   i_rate [gai_pkg::N_AXES],
    input  logic [62:0]          i_start_ns,
    input  logic [62:0]          i_end_ns,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [1:0]           o_status,
    output logic signed [63:0]   o_turn [gai_pkg::N_AXES]
);

    localparam int unsigned NA = gai_pkg::N_AXES;
    localparam int unsigned AW = gai_pkg::ADDR_W;
    localparam int unsigned CW = gai_pkg::CNT_W;

    logic [62:0]        mem_stamp [gai_pkg::SAMPLE_DEPTH];
    logic [63:0]        mem_ang   [NA][gai_pkg::SAMPLE_DEPTH];

    // Captured request.
    logic [1:0]         r_opcode;
    logic [62:0]        r_stamp;
    logic signed [31:0] r_rate [NA];
    logic [62:0]        r_start;
    logic [62:0]        r_end;

    // Integrator state.
    logic [CW-1:0]      r_held;
    logic [62:0]        r_first;
    logic [62:0]        r_last;
    logic signed [31:0] r_prev [NA];
    logic signed [63:0] r_run  [NA];
    logic signed [63:0] r_step [NA];

    // Search and interpolation.
    logic [CW-1:0]      r_lo;
    logic [CW-1:0]      r_hi;
    logic [CW-1:0]      r_mid;
    logic [62:0]        r_t;
    logic               r_side;
    logic [62:0]        r_shi;
    logic [62:0]        r_span;
    logic signed [63:0] r_ahi   [NA];
    logic signed [63:0] r_alo   [NA];
    logic signed [63:0] r_end_a [NA];
    logic signed [63:0] r_end_b [NA];
    logic signed [63:0] r_turn  [NA];

    // Arithmetic lanes.
    logic [127:0]       r_acc    [NA];
    logic [63:0]        r_mcand  [NA];
    logic [63:0]        r_mplier [NA];
    logic               r_neg    [NA];

    logic [62:0]        r_rd_stamp;
    logic signed [63:0] r_rd_ang [NA];

    logic               r_out_valid;
    logic [1:0]         r_status;
    logic signed [63:0] r_out_turn [NA];

    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic [CW-1:0]      held_m1;
    logic [CW-1:0]      lo_m1;
    logic [CW:0]        mid_sum;
    logic [62:0]        dt;

    logic [32:0]        psum   [NA];
    logic [32:0]        pmag   [NA];
    logic [127:0]       acc_p1 [NA];
    logic signed [63:0] step_v [NA];
    logic signed [63:0] run_nx [NA];
    logic [64:0]        dv_t   [NA];
    logic               dv_ge  [NA];
    logic [63:0]        dv_rem [NA];
    logic [63:0]        i_mag  [NA];
    logic signed [63:0] i_ang  [NA];
    logic signed [63:0] wr_ang [NA];

    assign held_m1 = r_held - 1'b1;
    assign lo_m1   = r_lo - 1'b1;
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign dt      = r_stamp - r_last;
    assign wr_addr = r_held[AW-1:0];
    assign wr_en   = (i_ctl.op == gai_pkg::DP_PUSH_FIRST) || (i_ctl.op == gai_pkg::DP_PUSH_WR);

    always_comb begin
        case (i_ctl.op)
            gai_pkg::DP_SRCH_RD:  rd_addr = mid_sum[AW:1];
            gai_pkg::DP_FETCH_HI: rd_addr = (r_lo >= r_held) ? held_m1[AW-1:0] : r_lo[AW-1:0];
            gai_pkg::DP_FETCH_LO: rd_addr = lo_m1[AW-1:0];
            default:              rd_addr = '0;
        endcase
    end

    always_comb begin
        for (int k = 0; k < NA; k++) begin
            psum[k]   = {r_rate[k][31], r_rate[k]} + {r_prev[k][31], r_prev[k]};
            pmag[k]   = psum[k][32] ? (33'd0 - psum[k]) : psum[k];
            acc_p1[k] = r_acc[k] + 128'd1;
            if (!r_neg[k]) begin
                step_v[k] = (|r_acc[k][127:64]) ? gai_pkg::ANG_MAX
                                                : signed'({1'b0, r_acc[k][63:1]});
            end else begin
                step_v[k] = (|acc_p1[k][127:64]) ? gai_pkg::ANG_MIN
                                                 : -signed'({1'b0, acc_p1[k][63:1]});
            end
            run_nx[k] = gai_pkg::sat_add(r_run[k], r_step[k]);
            wr_ang[k] = (i_ctl.op == gai_pkg::DP_PUSH_WR) ? run_nx[k] : r_run[k];
            dv_t[k]   = {r_acc[k][127:64], r_acc[k][63]};
            dv_ge[k]  = dv_t[k] >= {2'b00, r_span};
            dv_rem[k] = dv_ge[k] ? 64'(dv_t[k] - {2'b00, r_span}) : dv_t[k][63:0];
            i_mag[k]  = (r_ahi[k] >= r_rd_ang[k]) ? 64'(r_ahi[k] - r_rd_ang[k])
                                                  : 64'(r_rd_ang[k] - r_ahi[k]);
            i_ang[k]  = r_neg[k] ? (r_alo[k] - signed'(r_acc[k][63:0]))
                                 : (r_alo[k] + signed'(r_acc[k][63:0]));
        end
    end

    // Stores: one write port at the fill position, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_stamp[wr_addr] <= r_stamp;
        end
        r_rd_stamp <= mem_stamp[rd_addr];
        for (int k = 0; k < NA; k++) begin
            if (wr_en) begin
                mem_ang[k][wr_addr] <= wr_ang[k];
            end
            r_rd_ang[k] <= mem_ang[k][rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NA; k++) begin
                r_prev[k] <= '0;
                r_run[k]  <= '0;
            end
        end else begin
            if (i_ctl.op == gai_pkg::DP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_ctl.op)
                gai_pkg::DP_PUSH_FIRST: begin
                    r_held  <= r_held + 1'b1;
                    r_first <= r_stamp;
                    r_last  <= r_stamp;
                    for (int k = 0; k < NA; k++) r_prev[k] <= r_rate[k];
                end
                gai_pkg::DP_PUSH_WR: begin
                    r_held <= r_held + 1'b1;
                    r_last <= r_stamp;
                    for (int k = 0; k < NA; k++) begin
                        r_prev[k] <= r_rate[k];
                        r_run[k]  <= run_nx[k];
                    end
                end
                gai_pkg::DP_CLEAR: begin
                    r_held <= '0;
                    for (int k = 0; k < NA; k++) begin
                        r_prev[k] <= '0;
                        r_run[k]  <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            gai_pkg::DP_LOAD: begin
                r_opcode <= i_opcode;
                r_stamp  <= i_sample_ns;
                r_start  <= i_start_ns;
                r_end    <= i_end_ns;
                for (int k = 0; k < NA; k++) begin
                    r_rate[k] <= gai_pkg::rate_sext(i_rate[k]);
                    r_turn[k] <= '0;
                end
            end
            gai_pkg::DP_MUL_PUSH: begin
                for (int k = 0; k < NA; k++) begin
                    r_acc[k]    <= '0;
                    r_mcand[k]  <= {1'b0, dt};
                    r_mplier[k] <= {31'd0, pmag[k]};
                    r_neg[k]    <= psum[k][32];
                end
            end
            gai_pkg::DP_MUL_STEP: begin
                for (int k = 0; k < NA; k++) begin
                    r_acc[k]    <= {r_acc[k][126:0], 1'b0}
                                   + (r_mplier[k][63] ? {64'd0, r_mcand[k]} : 128'd0);
                    r_mplier[k] <= {r_mplier[k][62:0], 1'b0};
                end
            end
            gai_pkg::DP_PUSH_FIN: begin
                for (int k = 0; k < NA; k++) r_step[k] <= step_v[k];
            end
            gai_pkg::DP_SRCH_INIT: begin
                r_lo   <= '0;
                r_hi   <= r_held;
                r_side <= i_ctl.side;
                r_t    <= i_ctl.side ? r_start : r_end;
            end
            gai_pkg::DP_SRCH_RD: begin
                r_mid <= mid_sum[CW:1];
            end
            gai_pkg::DP_SRCH_CMP: begin
                if (r_rd_stamp < r_t) begin
                    r_lo <= r_mid + 1'b1;
                end else begin
                    r_hi <= r_mid;
                end
            end
            gai_pkg::DP_FETCH_LO: begin
                r_shi <= r_rd_stamp;
                for (int k = 0; k < NA; k++) r_ahi[k] <= r_rd_ang[k];
            end
            gai_pkg::DP_DIRECT: begin
                for (int k = 0; k < NA; k++) begin
                    if (r_side) r_end_a[k] <= r_rd_ang[k];
                    else        r_end_b[k] <= r_rd_ang[k];
                end
            end
            gai_pkg::DP_INTERP: begin
                r_span <= r_shi - r_rd_stamp;
                for (int k = 0; k < NA; k++) begin
                    r_acc[k]    <= '0;
                    r_mcand[k]  <= i_mag[k];
                    r_mplier[k] <= {1'b0, r_t - r_rd_stamp};
                    r_alo[k]    <= r_rd_ang[k];
                    r_neg[k]    <= r_ahi[k] < r_rd_ang[k];
                end
            end
            gai_pkg::DP_DIV_STEP: begin
                for (int k = 0; k < NA; k++) begin
                    r_acc[k] <= {dv_rem[k], r_acc[k][62:0], dv_ge[k]};
                end
            end
            gai_pkg::DP_INTERP_END: begin
                for (int k = 0; k < NA; k++) begin
                    if (r_side) r_end_a[k] <= i_ang[k];
                    else        r_end_b[k] <= i_ang[k];
                end
            end
            gai_pkg::DP_DIFF: begin
                for (int k = 0; k < NA; k++) begin
                    r_turn[k] <= gai_pkg::sat_sub(r_end_b[k], r_end_a[k]);
                end
            end
            gai_pkg::DP_EMIT: begin
                r_status <= i_ctl.code;
                for (int k = 0; k < NA; k++) r_out_turn[k] <= r_turn[k];
            end
            default: begin
            end
        endcase
    end

    assign o_sts.opcode     = r_opcode;
    assign o_sts.held_zero  = (r_held == '0);
    assign o_sts.not_rising = (r_stamp <= r_last);
    assign o_sts.full       = (r_held >= CW'(gai_pkg::SAMPLE_DEPTH));
    assign o_sts.query_bad  = (r_held < CW'(2)) || (r_start < r_first) || (r_start > r_last)
                              || (r_end < r_first) || (r_end > r_last);
    assign o_sts.srch_done  = (r_lo >= r_hi);
    assign o_sts.lo_edge    = (r_lo == '0) || (r_lo >= r_held);
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_turn      = r_out_turn;

endmodule

### sv/gai_controller.sv
// ----------------------------------------------------------------------------
// gai_controller
// Sequencer for push, query and clear requests; drives the datapath by
// command and reads back its status flags.
// ----------------------------------------------------------------------------
module gai_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gai_pkg::t_sts i_sts,
    output gai_pkg::t_ctl o_ctl
);

    typedef enum logic [12:0] {
        S_IDLE       = 13'b0000000000001,
        S_DECODE     = 13'b0000000000010,
        S_MUL        = 13'b0000000000100,
        S_PUSH_FIN   = 13'b0000000001000,
        S_PUSH_WR    = 13'b0000000010000,
        S_SRCH_RD    = 13'b0000000100000,
        S_SRCH_CMP   = 13'b0000001000000,
        S_FETCH_LO   = 13'b0000010000000,
        S_INTERP     = 13'b0000100000000,
        S_DIV        = 13'b0001000000000,
        S_INTERP_END = 13'b0010000000000,
        S_NEXT       = 13'b0100000000000,
        S_EMIT       = 13'b1000000000000
    } t_state;

    t_state                      r_state, n_state;
    logic [gai_pkg::STEP_W-1:0]  r_cnt, n_cnt;
    logic [1:0]                  r_code, n_code;
    logic                        r_side, n_side;
    logic                        cnt_last;

    assign cnt_last   = (r_cnt == gai_pkg::STEP_W'(gai_pkg::MUL_STEPS - 1));
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_code     = r_code;
        n_side     = r_side;
        o_ctl.op   = gai_pkg::DP_NONE;
        o_ctl.code = r_code;
        o_ctl.side = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.op = gai_pkg::DP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_EMIT;
                n_cnt   = '0;
                case (i_sts.opcode)
                    gai_pkg::OP_PUSH: begin
                        n_code = gai_pkg::ST_OK;
                        if (i_sts.held_zero) begin
                            o_ctl.op = gai_pkg::DP_PUSH_FIRST;
                        end else if (i_sts.not_rising) begin
                            n_code = gai_pkg::ST_DROPPED;
                        end else if (i_sts.full) begin
                            n_code = gai_pkg::ST_FULL;
                        end else begin
                            o_ctl.op = gai_pkg::DP_MUL_PUSH;
                            n_state  = S_MUL;
                        end
                    end
                    gai_pkg::OP_QUERY: begin
                        if (i_sts.query_bad) begin
                            n_code = gai_pkg::ST_INVALID;
                        end else begin
                            o_ctl.op   = gai_pkg::DP_SRCH_INIT;
                            o_ctl.side = 1'b0;
                            n_side     = 1'b0;
                            n_state    = S_SRCH_RD;
                        end
                    end
                    gai_pkg::OP_CLEAR: begin
                        o_ctl.op = gai_pkg::DP_CLEAR;
                        n_code   = gai_pkg::ST_OK;
                    end
                    default: begin
                        n_code = gai_pkg::ST_INVALID;
                    end
                endcase
            end
            S_MUL: begin
                o_ctl.op = gai_pkg::DP_MUL_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = (i_sts.opcode == gai_pkg::OP_QUERY) ? S_DIV : S_PUSH_FIN;
                end
            end
            S_PUSH_FIN: begin
                o_ctl.op = gai_pkg::DP_PUSH_FIN;
                n_state  = S_PUSH_WR;
            end
            S_PUSH_WR: begin
                o_ctl.op = gai_pkg::DP_PUSH_WR;
                n_code   = gai_pkg::ST_OK;
                n_state  = S_EMIT;
            end
            S_SRCH_RD: begin
                if (i_sts.srch_done) begin
                    o_ctl.op = gai_pkg::DP_FETCH_HI;
                    n_state  = S_FETCH_LO;
                end else begin
                    o_ctl.op = gai_pkg::DP_SRCH_RD;
                    n_state  = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                o_ctl.op = gai_pkg::DP_SRCH_CMP;
                n_state  = S_SRCH_RD;
            end
            S_FETCH_LO: begin
                // A time at or below the first stamp, or beyond the last, takes that end sample's angle.
                if (i_sts.lo_edge) begin
                    o_ctl.op = gai_pkg::DP_DIRECT;
                    n_state  = S_NEXT;
                end else begin
                    o_ctl.op = gai_pkg::DP_FETCH_LO;
                    n_state  = S_INTERP;
                end
            end
            S_INTERP: begin
                o_ctl.op = gai_pkg::DP_INTERP;
                n_cnt    = '0;
                n_state  = S_MUL;
            end
            S_DIV: begin
                o_ctl.op = gai_pkg::DP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = S_INTERP_END;
                end
            end
            S_INTERP_END: begin
                o_ctl.op = gai_pkg::DP_INTERP_END;
                n_state  = S_NEXT;
            end
            S_NEXT: begin
                if (!r_side) begin
                    o_ctl.op   = gai_pkg::DP_SRCH_INIT;
                    o_ctl.side = 1'b1;
                    n_side     = 1'b1;
                    n_state    = S_SRCH_RD;
                end else begin
                    o_ctl.op = gai_pkg::DP_DIFF;
                    n_code   = gai_pkg::ST_OK;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_ctl.op = gai_pkg::DP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_code  <= gai_pkg::ST_OK;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_code  <= n_code;
            r_side  <= n_side;
        end
    end

endmodule

### sv/gyro_angle_integrator.sv
// ----------------------------------------------------------------------------
// gyro_angle_integrator
// Three-axis trapezoidal gyro integrator with a time-indexed angle store and
// interval queries by binary search and linear interpolation.
// ----------------------------------------------------------------------------
//  Channel  Direction  Moves
//  i_in     in         request: opcode, sample_ns, rate_x/y/z, start_ns, end_ns
//  o_out    out        result: status, turn_x/y/z
//
// A request that produces no arithmetic (clear, first push, dropped, full,
// invalid) goes from decode straight to the result; an integrating push runs
// a 64-step shift-add multiply per axis, axes in parallel; a query runs, per
// interval end, a binary search of at most floor(log2(held)) + 1 steps, each a
// read and a compare, then a 64-step multiply and divide.
// Synchronous active-low reset empties the store and zeroes the angles; the
// stores need no clearing pass. A new request is taken once the previous
// result is registered, and a stalled result holds until taken.
module gyro_angle_integrator (
    input  logic     i_clk,
    input  logic     i_rst_n,
    gai_in_if.sink   i_in,
    gai_out_if.source o_out
);

    gai_pkg::t_ctl      ctl;
    gai_pkg::t_sts      sts;
    logic signed [31:0] rate [gai_pkg::N_AXES];
    logic signed [63:0] turn [gai_pkg::N_AXES];

    assign rate[0] = i_in.rate_x;
    assign rate[1] = i_in.rate_y;
    assign rate[2] = i_in.rate_z;

    gai_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    gai_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_opcode    (i_in.opcode),
        .i_sample_ns (i_in.sample_ns),
        .i_rate      (rate),
        .i_start_ns  (i_in.start_ns),
        .i_end_ns    (i_in.end_ns),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_status    (o_out.status),
        .o_turn      (turn)
    );

    assign o_out.turn_x = turn[0];
    assign o_out.turn_y = turn[1];
    assign o_out.turn_z = turn[2];

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Gyro angle integrator testbench
// Drives pushes, interval queries and clears through the request channel and
// checks every result against a cycle-free model of the integrator. Both
// channels stall at random, with one long result hold-off and two drain pauses.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         IDLE_PCT   = 28;
    localparam int         STALL_LIMIT = 8000;

    typedef struct {
        logic [1:0]         status;
        logic signed [63:0] turn_x;
        logic signed [63:0] turn_y;
        logic signed [63:0] turn_z;
    } t_turn;

    logic i_clk;
    logic i_rst_n;
    gai_in_if  req_if ();
    gai_out_if res_if ();

    gyro_angle_integrator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // Model state.
    logic [62:0]        mdl_stamp [gai_pkg::SAMPLE_DEPTH];
    logic signed [63:0] mdl_angle [3][gai_pkg::SAMPLE_DEPTH];
    int                 mdl_held;
    logic signed [31:0] mdl_prev [3];
    logic signed [63:0] mdl_run [3];

    t_turn turns_due [$];
    int    err_count;
    bit    calm;          // no idling on either side
    int    hold_off;      // cycles the receiver still refuses results
    int    stall_cycles;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic logic [62:0] rand63();
        return 63'({$urandom, $urandom});
    endfunction

    function automatic logic signed [63:0] clamp128(input logic signed [127:0] v);
        if (v > 128'(gai_pkg::ANG_MAX)) return gai_pkg::ANG_MAX;
        if (v < 128'(gai_pkg::ANG_MIN)) return gai_pkg::ANG_MIN;
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] trap_area(input logic signed [32:0] rsum,
                                                     input logic [62:0] dt);
        logic signed [127:0] a;
        logic signed [127:0] b;
        a = rsum;
        b = {65'd0, dt};
        return clamp128((a * b) >>> 1);
    endfunction

    function automatic logic signed [63:0] angle_at_time(input int ax, input logic [62:0] t);
        int lo_i, hi_i, mid;
        logic [127:0] prod;
        logic [63:0]  q, mag, span, off;
        logic signed [63:0] a_lo, a_hi;
        lo_i = 0;
        hi_i = mdl_held;
        while (lo_i < hi_i) begin
            mid = lo_i + (hi_i - lo_i) / 2;
            if (mdl_stamp[mid] < t) lo_i = mid + 1; else hi_i = mid;
        end
        if (lo_i == 0) return mdl_angle[ax][0];
        if (lo_i >= mdl_held) return mdl_angle[ax][mdl_held - 1];
        a_hi = mdl_angle[ax][lo_i];
        a_lo = mdl_angle[ax][lo_i - 1];
        span = 64'(mdl_stamp[lo_i] - mdl_stamp[lo_i - 1]);
        off  = 64'(t - mdl_stamp[lo_i - 1]);
        mag  = (a_hi >= a_lo) ? a_hi - a_lo : a_lo - a_hi;
        prod = {64'd0, off} * {64'd0, mag};
        q    = 64'(prod / {64'd0, span});
        return (a_hi >= a_lo) ? a_lo + q : a_lo - q;
    endfunction

    function automatic t_turn predict_turn(input logic [1:0] op, input logic [62:0] stamp,
                                           input logic signed [31:0] w [3],
                                           input logic [62:0] t0, input logic [62:0] t1);
        t_turn r;
        r = '{gai_pkg::ST_OK, 64'sd0, 64'sd0, 64'sd0};
        case (op)
            gai_pkg::OP_PUSH: begin
                if (mdl_held > 0) begin
                    if (stamp <= mdl_stamp[mdl_held - 1]) begin
                        r.status = gai_pkg::ST_DROPPED;
                        return r;
                    end
                    if (mdl_held >= gai_pkg::SAMPLE_DEPTH) begin
                        r.status = gai_pkg::ST_FULL;
                        return r;
                    end
                    for (int k = 0; k < 3; k++) begin
                        mdl_run[k] = clamp128(128'(mdl_run[k])
                                     + 128'(trap_area(33'(w[k]) + 33'(mdl_prev[k]),
                                                      stamp - mdl_stamp[mdl_held - 1])));
                    end
                end
                mdl_stamp[mdl_held] = stamp;
                for (int k = 0; k < 3; k++) begin
                    mdl_angle[k][mdl_held] = mdl_run[k];
                    mdl_prev[k] = w[k];
                end
                mdl_held++;
            end
            gai_pkg::OP_QUERY: begin
                if (mdl_held < 2 || t0 < mdl_stamp[0] || t0 > mdl_stamp[mdl_held - 1]
                    || t1 < mdl_stamp[0] || t1 > mdl_stamp[mdl_held - 1]) begin
                    r.status = gai_pkg::ST_INVALID;
                    return r;
                end
                r.turn_x = clamp128(128'(angle_at_time(0, t1)) - 128'(angle_at_time(0, t0)));
                r.turn_y = clamp128(128'(angle_at_time(1, t1)) - 128'(angle_at_time(1, t0)));
                r.turn_z = clamp128(128'(angle_at_time(2, t1)) - 128'(angle_at_time(2, t0)));
            end
            gai_pkg::OP_CLEAR: begin
                mdl_held = 0;
                for (int k = 0; k < 3; k++) begin
                    mdl_prev[k] = 32'sd0;
                    mdl_run[k]  = 64'sd0;
                end
            end
            default: r.status = gai_pkg::ST_INVALID;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    // Sends one request; called at a rising edge, returns at a rising edge.
    task automatic send_request(input logic [1:0] op, input logic [62:0] stamp,
                                input logic signed [31:0] wx, input logic signed [31:0] wy,
                                input logic signed [31:0] wz,
                                input logic [62:0] t0, input logic [62:0] t1);
        logic signed [31:0] w [3];
        t_turn due;
        w = '{wx, wy, wz};
        req_if.valid     <= 1'b1;
        req_if.opcode    <= op;
        req_if.sample_ns <= stamp;
        req_if.rate_x    <= wx;
        req_if.rate_y    <= wy;
        req_if.rate_z    <= wz;
        req_if.start_ns  <= t0;
        req_if.end_ns    <= t1;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        due = predict_turn(op, stamp, w, t0, t1);
        turns_due.insert(turns_due.size(), due);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic push(input logic [62:0] stamp, input logic signed [31:0] wx,
                        input logic signed [31:0] wy, input logic signed [31:0] wz);
        send_request(gai_pkg::OP_PUSH, stamp, wx, wy, wz, rand63(), rand63());
    endtask

    task automatic query(input logic [62:0] t0, input logic [62:0] t1);
        send_request(gai_pkg::OP_QUERY, rand63(), $urandom, $urandom, $urandom, t0, t1);
    endtask

    task automatic clear_store();
        send_request(gai_pkg::OP_CLEAR, rand63(), $urandom, $urandom, $urandom,
                     rand63(), rand63());
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (turns_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_rate();
        case ($urandom_range(7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'(int'($urandom_range(200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [62:0] rand_gap();
        case ($urandom_range(9))
            0: return 63'({$urandom, $urandom} >> $urandom_range(1, 40));
            1: return 63'({32'd0, $urandom});
            default: return 63'($urandom_range(1, 1000));
        endcase
    endfunction

    function automatic logic [62:0] rand_in_range();
        logic [63:0] first, width;
        first = 64'(mdl_stamp[0]);
        width = 64'(mdl_stamp[mdl_held - 1]) - 64'(mdl_stamp[0]) + 64'd1;
        if ($urandom_range(3) == 0) return mdl_stamp[$urandom_range(mdl_held - 1)];
        return 63'(first + ({$urandom, $urandom} % width));
    endfunction

    task automatic test_directed();
        query(63'd0, 63'd0);                      // empty store
        send_request(OP_UNUSED, '1, '1, '1, '1, '1, '1);
        push(63'd100, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd5);
        query(63'd100, 63'd100);                  // only one sample held
        push(63'd100, 32'sd1, 32'sd1, 32'sd1);     // equal stamp is dropped
        push(63'd50, 32'sd1, 32'sd1, 32'sd1);      // falling stamp is dropped
        push(63'd1100, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd7);
        push(63'd1103, 32'sd0, -32'sd1, 32'sd3);
        query(63'd100, 63'd1103);
        query(63'd1103, 63'd100);                 // reversed interval
        query(63'd101, 63'd1102);                 // interpolated ends
        query(63'd1100, 63'd1100);
        query(63'd99, 63'd1103);                  // below first stamp
        query(63'd100, 63'd1104);                 // above last stamp
        push({1'b0, {62{1'b1}}}, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        push({63{1'b1}}, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        query(63'd500, {63{1'b1}});               // saturated angles
        query({63{1'b1}}, 63'd0);
        clear_store();
        query(63'd100, 63'd100);
        push(63'd0, 32'sd3, 32'sd3, 32'sd3);
        push(63'd1, 32'sd3, 32'sd3, 32'sd3);
        query(63'd0, 63'd1);
    endtask

    task automatic test_full_store();
        logic [62:0] t;
        clear_store();
        t = rand63() >> 2;
        calm = 1'b1;
        for (int i = 0; i < gai_pkg::SAMPLE_DEPTH; i++) begin
            push(t, rand_rate(), rand_rate(), rand_rate());
            t = t + 63'($urandom_range(1, 50));
        end
        calm = 1'b0;
        push(t, 32'sd1, 32'sd1, 32'sd1);          // store full
        push(63'd0, 32'sd1, 32'sd1, 32'sd1);      // dropped beats full
        query(mdl_stamp[0], mdl_stamp[gai_pkg::SAMPLE_DEPTH - 1]);
        query(rand_in_range(), rand_in_range());
    endtask

    task automatic test_receiver_hold();
        hold_off = 400;
        for (int i = 0; i < 6; i++) push(rand63(), rand_rate(), 0, 0);
    endtask

    task automatic test_random(input int n_items);
        int sent, n;
        logic [62:0] t;
        logic [62:0] gap;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(3) != 0) begin
                clear_store();
                sent++;
            end
            t = 63'({$urandom, $urandom} >> $urandom_range(0, 62));
            n = $urandom_range(2, 14);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(9) == 0 && mdl_held > 0)
                    push(mdl_stamp[mdl_held - 1] - $urandom_range(0, 3), rand_rate(),
                         rand_rate(), rand_rate());
                else
                    push(t, rand_rate(), rand_rate(), rand_rate());
                gap = rand_gap();
                if (t > {63{1'b1}} - gap - 63'd1) break;
                t += gap;
                sent++;
            end
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) begin
                if (mdl_held >= 2 && $urandom_range(4) != 0) query(rand_in_range(), rand_in_range());
                else query(rand63(), rand63());
                sent++;
            end
            if ($urandom_range(15) == 0) begin
                send_request(OP_UNUSED, rand63(), $urandom, $urandom, $urandom,
                             rand63(), rand63());
                sent++;
            end
        end
    endtask

    // Result checker and receiver stalls.
    always @(posedge i_clk) begin
        t_turn want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (turns_due.size() == 0) begin
                report_mismatch("unexpected result", 64'(res_if.status), 64'(0));
            end else begin
                want = turns_due.pop_front();
                if (res_if.status !== want.status)
                    report_mismatch("status", 64'(res_if.status), 64'(want.status));
                if (res_if.turn_x !== want.turn_x)
                    report_mismatch("turn_x", res_if.turn_x, want.turn_x);
                if (res_if.turn_y !== want.turn_y)
                    report_mismatch("turn_y", res_if.turn_y, want.turn_y);
                if (res_if.turn_z !== want.turn_z)
                    report_mismatch("turn_z", res_if.turn_z, want.turn_z);
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles without any request or result moving.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        err_count = 0;
        calm = 1'b0;
        hold_off = 0;
        stall_cycles = 0;
        mdl_held = 0;
        for (int k = 0; k < 3; k++) begin
            mdl_prev[k] = 32'sd0;
            mdl_run[k]  = 64'sd0;
        end
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.opcode    <= gai_pkg::OP_PUSH;
        req_if.sample_ns <= '0;
        req_if.rate_x    <= '0;
        req_if.rate_y    <= '0;
        req_if.rate_z    <= '0;
        req_if.start_ns  <= '0;
        req_if.end_ns    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drained();
        @(posedge i_clk);
        test_receiver_hold();
        test_full_store();
        calm = 1'b1;
        test_random(30);
        calm = 1'b0;
        test_random(120);

        wait_drained();
        repeat (400) @(posedge i_clk);
        if (err_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
